// ===== hw/rtl/ordered_list_engine_assert.svh =====
// Assertion macros for the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define OLE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ordered_list_engine: assertion failed");
`define OLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_list_engine: assertion failed");
`else
`define OLE_ASSERT_ALWAYS(label, cond)
`define OLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/olist_pkg.sv =====
// Shared types and codes of the ordered list engine.
`timescale 1ns / 1ps

package olist_pkg;

  localparam int POS_W = 6;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    KIND_INS_HEAD   = 3'd0,
    KIND_INS_TAIL   = 3'd1,
    KIND_INS_BEFORE = 3'd2,
    KIND_DEL_HEAD   = 3'd3,
    KIND_DEL_TAIL   = 3'd4,
    KIND_DEL_VALUE  = 3'd5,
    KIND_SEARCH     = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    pos_t    position;
    pos_t    length;
    logic    last;
  } result_t;

endpackage

// ===== hw/rtl/olist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/olist_ctrl.sv =====
// Sequencer that scans and shifts list entries through the RAM ports.
`timescale 1ns / 1ps

module olist_ctrl #(
  parameter int CAPACITY = 32,
  parameter int IW       = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [2:0]          kind,
  input  logic signed [31:0]  value,
  input  logic signed [31:0]  anchor,
  output logic                emit_valid,
  input  logic                emit_ready,
  output olist_pkg::result_t  emit,
  output logic                we,
  output logic [IW-1:0]       waddr,
  output logic [31:0]         wdata,
  output logic [IW-1:0]       raddr,
  input  logic [31:0]         rdata
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHR_PRE,
    S_SHR,
    S_SHL_PRE,
    S_SHL,
    S_EMIT
  } state_t;

  state_t              state;
  olist_pkg::kind_t    op;
  olist_pkg::status_t  res_status;
  olist_pkg::pos_t     res_pos;
  logic [CW-1:0]       len;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       tgt;
  logic [CW-1:0]       pend_pos;
  logic                pend_valid;
  logic [31:0]         key;
  logic [31:0]         val;

  logic [CW-1:0] idx_p1, idx_p2, idx_m2, len_m1, tgt_p1;
  logic          hit, at_end, is_search, scan_stall, full, empty;

  assign idx_p1    = idx + CW'(1);
  assign idx_p2    = idx + CW'(2);
  assign idx_m2    = idx - CW'(2);
  assign len_m1    = len - CW'(1);
  assign tgt_p1    = tgt + CW'(1);
  assign hit       = (rdata == key);
  assign at_end    = (idx == len_m1);
  assign is_search = (op == olist_pkg::KIND_SEARCH);
  assign scan_stall = is_search && hit && pend_valid && !emit_ready;
  assign full      = (len >= CW'(CAPACITY));
  assign empty     = (len == '0);
  assign req_ready = (state == S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = idx[IW-1:0];
    wdata = rdata;
    raddr = '0;
    emit_valid      = 1'b0;
    emit.status     = res_status;
    emit.position   = res_pos;
    emit.length     = olist_pkg::pos_t'(len);
    emit.last       = 1'b1;
    unique case (state)
      S_IDLE: begin
        raddr = '0;
      end
      S_SCAN: begin
        raddr = scan_stall ? idx[IW-1:0] : idx_p1[IW-1:0];
        if (is_search && hit && pend_valid) begin
          emit_valid    = 1'b1;
          emit.status   = olist_pkg::ST_OK;
          emit.position = olist_pkg::pos_t'(pend_pos);
          emit.last     = 1'b0;
        end
      end
      S_SHR_PRE: begin
        raddr = len_m1[IW-1:0];
      end
      S_SHR: begin
        raddr = idx_m2[IW-1:0];
        we    = 1'b1;
        wdata = (idx == tgt) ? val : rdata;
      end
      S_SHL_PRE: begin
        raddr = tgt_p1[IW-1:0];
      end
      S_SHL: begin
        raddr = idx_p2[IW-1:0];
        we    = (idx_p1 != len);
      end
      S_EMIT: begin
        emit_valid = 1'b1;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= olist_pkg::kind_t'(kind);
            val        <= value;
            key        <= (olist_pkg::kind_t'(kind) == olist_pkg::KIND_INS_BEFORE) ?
                          anchor : value;
            idx        <= '0;
            pend_valid <= 1'b0;
            res_pos    <= '0;
            unique case (olist_pkg::kind_t'(kind)) inside
              olist_pkg::KIND_INS_HEAD: begin
                if (full) begin
                  res_status <= olist_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olist_pkg::ST_OK;
                  tgt        <= '0;
                  state      <= S_SHR_PRE;
                end
              end
              olist_pkg::KIND_INS_TAIL: begin
                if (full) begin
                  res_status <= olist_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olist_pkg::ST_OK;
                  tgt        <= len;
                  state      <= S_SHR_PRE;
                end
              end
              olist_pkg::KIND_INS_BEFORE: begin
                if (full) begin
                  res_status <= olist_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else if (empty) begin
                  res_status <= olist_pkg::ST_OK;
                  tgt        <= '0;
                  state      <= S_SHR_PRE;
                end else begin
                  res_status <= olist_pkg::ST_OK;
                  state      <= S_SCAN;
                end
              end
              olist_pkg::KIND_DEL_HEAD: begin
                if (empty) begin
                  res_status <= olist_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olist_pkg::ST_OK;
                  tgt        <= '0;
                  state      <= S_SHL_PRE;
                end
              end
              olist_pkg::KIND_DEL_TAIL: begin
                if (empty) begin
                  res_status <= olist_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olist_pkg::ST_OK;
                  tgt        <= len_m1;
                  state      <= S_SHL_PRE;
                end
              end
              olist_pkg::KIND_DEL_VALUE, olist_pkg::KIND_SEARCH: begin
                if (empty) begin
                  res_status <= (olist_pkg::kind_t'(kind) == olist_pkg::KIND_SEARCH) ?
                                olist_pkg::ST_NOT_FOUND : olist_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olist_pkg::ST_OK;
                  state      <= S_SCAN;
                end
              end
              default: begin
                res_status <= olist_pkg::ST_OK;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (is_search) begin
            if (!scan_stall) begin
              if (hit) begin
                pend_valid <= 1'b1;
                pend_pos   <= idx_p1;
              end
              if (at_end) begin
                res_status <= (hit || pend_valid) ? olist_pkg::ST_OK :
                              olist_pkg::ST_NOT_FOUND;
                res_pos    <= hit ? olist_pkg::pos_t'(idx_p1) :
                              (pend_valid ? olist_pkg::pos_t'(pend_pos) : '0);
                state      <= S_EMIT;
              end else begin
                idx <= idx_p1;
              end
            end
          end else if (hit) begin
            tgt   <= idx;
            state <= (op == olist_pkg::KIND_INS_BEFORE) ? S_SHR_PRE : S_SHL_PRE;
          end else if (at_end) begin
            res_status <= olist_pkg::ST_NOT_FOUND;
            state      <= S_EMIT;
          end else begin
            idx <= idx_p1;
          end
        end
        S_SHR_PRE: begin
          idx   <= len;
          state <= S_SHR;
        end
        S_SHR: begin
          if (idx == tgt) begin
            len   <= len + CW'(1);
            state <= S_EMIT;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_SHL_PRE: begin
          idx   <= tgt;
          state <= S_SHL;
        end
        S_SHL: begin
          if (idx_p1 == len) begin
            len   <= len_m1;
            state <= S_EMIT;
          end else begin
            idx <= idx_p1;
          end
        end
        S_EMIT: begin
          if (emit_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// Top level of the ordered list engine: sequencer, entry RAM and result register.
//
//   channel   | handshake            | payload
//   ----------+----------------------+--------------------------------
//   request   | req_valid, req_ready | kind, value, anchor
//   result    | res_valid, res_ready | status, position, length, last
//
// Steps: a request without a scan or move goes straight to its result; an insert
// or delete shifts the later entries one at a time, and a match by value first
// scans entry by entry; a search scans the whole list. One RAM read port and
// one compare set this pace. Reset empties the list at once. A full result
// register stalls the sequencer, and requests are taken only when it is idle.
`timescale 1ns / 1ps

module ordered_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  input  logic signed [31:0] anchor,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         status,
  output logic [5:0]         position,
  output logic [5:0]         length,
  output logic               last
);

  localparam int IW = $clog2(CAPACITY);

  olist_pkg::result_t emit;
  olist_pkg::result_t res;
  logic               emit_valid;
  logic               emit_ready;
  logic               we;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      raddr;
  logic [31:0]        wdata;
  logic [31:0]        rdata;

  olist_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .kind       (kind),
    .value      (value),
    .anchor     (anchor),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit       (emit),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  olist_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign emit_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (emit_valid && emit_ready) begin
        res_valid <= 1'b1;
        res       <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign status   = res.status;
  assign position = res.position;
  assign length   = res.length;
  assign last     = res.last;

  `include "ordered_list_engine_assert.svh"

  `OLE_ASSERT_ALWAYS(a_idle_no_emit, !(req_ready && emit_valid))
  `OLE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  `OLE_ASSERT_ALWAYS(a_mid_ok, !(emit_valid && !emit.last) || (emit.status == olist_pkg::ST_OK))
  `OLE_ASSERT_ALWAYS(a_mid_pos, !(res_valid && !last) || (position != '0))

endmodule
